[design/stack_queue_engine_defines.svh]
// ---------------------------------------------------------------------------
// stack_queue_engine_defines
// Assertion macros used by the stack/queue engine RTL (sqe_ctrl)
// ---------------------------------------------------------------------------
`ifndef STACK_QUEUE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SQE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SQE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sqe_pkg.sv]
// ---------------------------------------------------------------------------
// sqe_pkg
// Types, codes and sizing constants of the stack/queue engine
// ---------------------------------------------------------------------------
package sqe_pkg;

	// default store depth and entry width
	localparam int SQE_DEPTH = 64;
	localparam int DATA_W    = 32;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_STACK_MODE = 1'b0;

	// command codes (5 to 7 are unused and answered with ok)
	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_DUMP = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_POP  = 3'd3,
		CMD_SWAP = 3'd4
	} cmd_e;

	// result status codes
	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_ARG     = 3'd1,
		STAT_FULL        = 3'd2,
		STAT_PEEK_EMPTY  = 3'd3,
		STAT_POP_EMPTY   = 3'd4,
		STAT_SWAP_SHORT  = 3'd5
	} status_e;

	// control sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_PEEK,
		S_SWAP_A,
		S_SWAP_B,
		S_DUMP
	} state_e;

	// input item
	typedef struct packed {
		cmd_e               cmd;
		logic signed [31:0] push_value;
		logic               arg_ok;
	} cmd_item_t;

	// result item
	typedef struct packed {
		logic signed [31:0] value;
		logic               has_value;
		status_e            status;
		logic               last;
	} rsp_item_t;

endpackage

[design/stack_queue_engine.sv]
// ---------------------------------------------------------------------------
// stack_queue_engine
// Data store of a stack machine held as a circular buffer, with push at
// top or bottom, pop, peek, swap of the top two and a full dump
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   cmd       in         cmd_valid / cmd_stall  cmd_data   (cmd_item_t)
//   rsp       out        rsp_valid / rsp_stall  rsp_data   (rsp_item_t)
//   apb       in         psel / penable         paddr, pwdata, prdata
//
// push, pop, unused codes and every failing command need no memory read.
// peek and swap both go through the single read port of the entry memory,
// peek as a read, swap as a read, a read-and-write, and a write.
// dump reads out every stored entry in turn, one result per entry.
// after reset the store is empty at once; there is no clearing pass.
// while rsp_stall holds the result register, peek, dump and S_RESP wait in place.
// ---------------------------------------------------------------------------
module stack_queue_engine #(
	parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  sqe_pkg::cmd_item_t          cmd_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output sqe_pkg::rsp_item_t          rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sqe_pkg::PADDR_W-1:0] paddr,
	input  logic [sqe_pkg::PDATA_W-1:0] pwdata,
	output logic [sqe_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	import sqe_pkg::*;

	logic stack_mode_q;
	logic reg_sel;
	logic reg_write;

	// register decode, one register selected while paddr bit 2 is 0 (byte addresses 0 to 3)
	assign pready    = 1'b1;
	assign reg_sel   = (paddr[PADDR_W-1] == REG_IDX_STACK_MODE);
	assign reg_write = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_mode_q <= 1'b1;
		end else if (reg_write) begin
			stack_mode_q <= pwdata[0];
		end
	end

	// read back
	assign prdata = reg_sel ? PDATA_W'(stack_mode_q) : '0;

	// command sequencer with entry store
	sqe_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_mode (stack_mode_q),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

endmodule

[design/sqe_ram.sv]
// ---------------------------------------------------------------------------
// sqe_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module sqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, and read port returning the old contents on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/sqe_ctrl.sv]
// ---------------------------------------------------------------------------
// sqe_ctrl
// Command sequencer: top/count bookkeeping, memory read-modify-write and
// the result register
// ---------------------------------------------------------------------------
`include "stack_queue_engine_defines.svh"

module sqe_ctrl #(
	parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  stack_mode,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  sqe_pkg::cmd_item_t    cmd_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output sqe_pkg::rsp_item_t    rsp_data
);

	import sqe_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_e         state_q, state_d;
	logic [AW-1:0]  top_q, top_d;
	logic [CW-1:0]  count_q, count_d;
	logic [AW-1:0]  slot_q, slot_d;
	logic [CW-1:0]  rem_q, rem_d;
	status_e        status_q, status_d;
	logic           rsp_valid_q;
	rsp_item_t      rsp_data_q;

	logic           accept;
	logic           can_emit;
	logic           load_rsp;
	rsp_item_t      rsp_next;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [31:0]    ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [31:0]    ram_rdata;

	logic [AW-1:0]  top_dec;
	logic [AW-1:0]  top_inc;
	logic [AW-1:0]  slot_inc;
	logic [AW:0]    tail_sum;
	logic [AW-1:0]  tail;
	logic           is_full;
	logic           is_empty;
	logic           dump_last;

	status_e        dec_status;
	logic           dec_quick;

	// entry store
	sqe_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshake
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign can_emit  = !rsp_valid_q || !rsp_stall;

	// circular index arithmetic
	assign top_dec  = (top_q == '0) ? AW'(DEPTH - 1) : top_q - 1'b1;
	assign top_inc  = (top_q == AW'(DEPTH - 1)) ? '0 : top_q + 1'b1;
	assign slot_inc = (slot_q == AW'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign tail_sum = (AW+1)'(top_q) + (AW+1)'(count_q);
	assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
		: AW'(tail_sum);
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign dump_last = (rem_q == CW'(1));

	// command decode: status and whether a single result follows without a memory read
	always_comb begin
		dec_status = STAT_OK;
		dec_quick  = 1'b1;
		unique case (cmd_data.cmd)
			CMD_PUSH: begin
				if (!cmd_data.arg_ok) begin
					dec_status = STAT_BAD_ARG;
				end else if (is_full) begin
					dec_status = STAT_FULL;
				end
			end
			CMD_DUMP: begin
				dec_quick = 1'b0;
			end
			CMD_PEEK: begin
				if (is_empty) begin
					dec_status = STAT_PEEK_EMPTY;
				end else begin
					dec_quick = 1'b0;
				end
			end
			CMD_POP: begin
				if (is_empty) begin
					dec_status = STAT_POP_EMPTY;
				end
			end
			CMD_SWAP: begin
				if (count_q < CW'(2)) begin
					dec_status = STAT_SWAP_SHORT;
				end else begin
					dec_quick = 1'b0;
				end
			end
			default: begin
				dec_status = STAT_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (dec_quick) begin
						state_d = can_emit ? S_IDLE : S_RESP;
					end else if (cmd_data.cmd == CMD_PEEK) begin
						state_d = S_PEEK;
					end else if (cmd_data.cmd == CMD_SWAP) begin
						state_d = S_SWAP_A;
					end else begin
						state_d = is_empty ? S_IDLE : S_DUMP;
					end
				end
			end
			S_RESP: begin
				if (can_emit) begin
					state_d = S_IDLE;
				end
			end
			S_PEEK: begin
				if (can_emit) begin
					state_d = S_IDLE;
				end
			end
			S_SWAP_A: begin
				state_d = S_SWAP_B;
			end
			S_SWAP_B: begin
				state_d = can_emit ? S_IDLE : S_RESP;
			end
			S_DUMP: begin
				if (can_emit && dump_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory accesses, bookkeeping and result assembly
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = top_q;
		ram_wdata = cmd_data.push_value;
		ram_re    = 1'b0;
		ram_raddr = top_q;
		top_d     = top_q;
		count_d   = count_q;
		slot_d    = slot_q;
		rem_d     = rem_q;
		status_d  = status_q;
		load_rsp  = 1'b0;
		rsp_next  = '{value: '0, has_value: 1'b0, status: status_q, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = dec_status;
					if (dec_quick && can_emit) begin
						load_rsp        = 1'b1;
						rsp_next.status = dec_status;
					end
					if (dec_status == STAT_OK) begin
						unique case (cmd_data.cmd)
							CMD_PUSH: begin
								ram_we    = 1'b1;
								ram_waddr = stack_mode ? top_dec : tail;
								count_d   = count_q + 1'b1;
								if (stack_mode) begin
									top_d = top_dec;
								end
							end
							CMD_POP: begin
								top_d   = top_inc;
								count_d = count_q - 1'b1;
							end
							CMD_PEEK, CMD_SWAP: begin
								ram_re = 1'b1;
							end
							CMD_DUMP: begin
								ram_re = !is_empty;
								slot_d = top_q;
								rem_d  = count_q;
							end
							default: begin
								ram_re = 1'b0;
							end
						endcase
					end
				end
			end
			S_RESP: begin
				load_rsp = can_emit;
			end
			S_PEEK: begin
				load_rsp           = can_emit;
				rsp_next.value     = ram_rdata;
				rsp_next.has_value = 1'b1;
			end
			S_SWAP_A: begin
				// second entry takes the first, and its old value is read out
				ram_we    = 1'b1;
				ram_waddr = top_inc;
				ram_wdata = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = top_inc;
			end
			S_SWAP_B: begin
				ram_we    = 1'b1;
				ram_waddr = top_q;
				ram_wdata = ram_rdata;
				load_rsp  = can_emit;
			end
			S_DUMP: begin
				rsp_next.value     = ram_rdata;
				rsp_next.has_value = 1'b1;
				rsp_next.last      = dump_last;
				if (can_emit) begin
					load_rsp = 1'b1;
					rem_d    = rem_q - 1'b1;
					if (!dump_last) begin
						ram_re    = 1'b1;
						ram_raddr = slot_inc;
						slot_d    = slot_inc;
					end
				end
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			status_q    <= STAT_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			top_q    <= top_d;
			count_q  <= count_d;
			rem_q    <= rem_d;
			status_q <= status_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		if (load_rsp) begin
			rsp_data_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// checks
	`SQE_ASSERT_IMPLIES(a_count_range, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`SQE_ASSERT_IMPLIES(a_top_range, 1'b1, top_q <= AW'(DEPTH - 1), "top index out of range")
	`SQE_ASSERT_IMPLIES(a_dump_live, state_q == S_DUMP, rem_q != '0 && rem_q <= count_q, "dump walk count broken")
	`SQE_ASSERT_IMPLIES(a_dump_no_write, state_q == S_DUMP, !ram_we, "store written during dump")
	`SQE_ASSERT_NEXT(a_swap_seq, state_q == S_SWAP_A, state_q == S_SWAP_B && $stable(count_q), "swap sequence broken")

endmodule
